// File: rtl/lbps_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer - shared package
// Widths, register indexes, phase type, hand-off structs and time tables.
// ----------------------------------------------------------------------------
package lbps_pkg;

   // default configuration of the sequencer
   localparam int LBPS_PATTERN_LEN  = 8;
   localparam int LBPS_RATE_ENTRIES = 15;

   // fixed field widths
   localparam int LED_W      = 4;
   localparam int STEP_OUT_W = 3;
   localparam int RATE_W     = 4;
   localparam int HOLD_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // entries held in the pattern word
   localparam int PATTERN_SLOTS = CSR_DATA_W / LED_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_SELECT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERRIDE_HOLD = 2'd2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] PATTERN_RESET = 32'h0101_0101;
   localparam logic [RATE_W-1:0]     RATE_RESET    = 4'd14;

   // blink phase
   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_ON    = 2'd1,
      PH_OFF   = 2'd2
   } phase_type;

   // configuration seen by the sequencer
   typedef struct packed {
      logic [CSR_DATA_W-1:0] pattern_words;
      logic [RATE_W-1:0]     rate_select;
      logic                  override_hold;
   } cfg_type;

   // result fields of one item
   typedef struct packed {
      logic [LED_W-1:0]      led_state;
      logic [STEP_OUT_W-1:0] step_index;
      logic                  in_on_phase;
   } result_type;

   // on time in ms per rate code
   function automatic logic [HOLD_W-1:0] on_time(input logic [RATE_W-1:0] code);
      logic [HOLD_W-1:0] t;
      case (code)
         4'd0:    t = 10'd40;
         4'd1:    t = 10'd44;
         4'd2:    t = 10'd50;
         4'd3:    t = 10'd57;
         4'd4:    t = 10'd67;
         4'd5:    t = 10'd80;
         4'd6:    t = 10'd100;
         4'd7:    t = 10'd133;
         4'd8:    t = 10'd160;
         4'd9:    t = 10'd200;
         4'd10:   t = 10'd240;
         4'd11:   t = 10'd267;
         4'd12:   t = 10'd400;
         4'd13:   t = 10'd500;
         default: t = 10'd750;
      endcase
      return t;
   endfunction

   // off time in ms per rate code
   function automatic logic [HOLD_W-1:0] off_time(input logic [RATE_W-1:0] code);
      logic [HOLD_W-1:0] t;
      case (code)
         4'd0:    t = 10'd10;
         4'd1:    t = 10'd11;
         4'd2:    t = 10'd13;
         4'd3:    t = 10'd14;
         4'd4:    t = 10'd16;
         4'd5:    t = 10'd20;
         4'd6:    t = 10'd25;
         4'd7:    t = 10'd34;
         4'd8:    t = 10'd40;
         4'd9:    t = 10'd50;
         4'd10:   t = 10'd58;
         4'd11:   t = 10'd66;
         4'd12:   t = 10'd100;
         4'd13:   t = 10'd130;
         default: t = 10'd750;
      endcase
      return t;
   endfunction

endpackage

// File: rtl/lbps_req_if.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer - request channel
// Valid/ready channel carrying one action item.
// ----------------------------------------------------------------------------
interface lbps_req_if
   import lbps_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [LED_W-1:0] led_value;

   modport source (output valid, output action, output led_value, input ready);
   modport sink   (input valid, input action, input led_value, output ready);
endinterface

// File: rtl/lbps_rsp_if.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer - response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface lbps_rsp_if
   import lbps_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [LED_W-1:0]      led_state;
   logic [STEP_OUT_W-1:0] step_index;
   logic                  in_on_phase;

   modport source (output valid, output led_state, output step_index,
                   output in_on_phase, input ready);
   modport sink   (input valid, input led_state, input step_index,
                   input in_on_phase, output ready);
endinterface

// File: rtl/lbps_csr.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer - configuration registers
// Write-only register file: pattern words, rate select and override hold.
// ----------------------------------------------------------------------------
module lbps_csr
   import lbps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   logic [CSR_DATA_W-1:0] pattern_ff, pattern_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic                  hold_ff, hold_in;

   // decode a write
   always_comb begin
      pattern_in = pattern_ff;
      rate_in    = rate_ff;
      hold_in    = hold_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_WORDS: pattern_in = csr_wr_data;
            CSR_RATE_SELECT:   rate_in    = csr_wr_data[RATE_W-1:0];
            CSR_OVERRIDE_HOLD: hold_in    = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PATTERN_RESET;
         rate_ff    <= RATE_RESET;
         hold_ff    <= 1'b0;
      end else begin
         pattern_ff <= pattern_in;
         rate_ff    <= rate_in;
         hold_ff    <= hold_in;
      end
   end

   assign cfg.pattern_words = pattern_ff;
   assign cfg.rate_select   = rate_ff;
   assign cfg.override_hold = hold_ff;

endmodule

// File: rtl/lbps_seq.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer - step engine
// Holds LED, step, phase and hold count state; updates it once per item and
// presents the result of that item for the output register.
// ----------------------------------------------------------------------------
module lbps_seq
   import lbps_pkg::*;
#(
   parameter int PATTERN_LEN  = LBPS_PATTERN_LEN,
   parameter int RATE_ENTRIES = LBPS_RATE_ENTRIES
)(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             item_en,
   input  logic             action,
   input  logic [LED_W-1:0] led_value,
   output result_type       result
);

   localparam int SW = (PATTERN_LEN > 2) ? $clog2(PATTERN_LEN) : 1;
   localparam logic [SW:0] PLEN = (SW+1)'(PATTERN_LEN);
   localparam int RLIM_I = (RATE_ENTRIES > 15) ? 15 : ((RATE_ENTRIES < 1) ? 1 : RATE_ENTRIES);
   localparam logic [RATE_W-1:0] RATE_LIM  = RATE_W'(RLIM_I);
   localparam logic [RATE_W-1:0] RATE_LAST = RATE_W'(RLIM_I - 1);

   logic [LED_W-1:0]  leds_ff, leds_in;
   logic [SW-1:0]     step_ff, step_in;
   phase_type         phase_ff, phase_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;

   logic [SW+2:0]       step_ext;
   logic [SW:0]         step_inc;
   logic [SW-1:0]       step_nx;
   logic [LED_W-1:0]    entry;
   logic                rate_ok;
   logic [RATE_W-1:0]   rate_cl;
   logic                do_on, do_off, apply_en;

   // pattern entry at the current step, and the wrapped next step
   always_comb begin
      step_ext = {3'b000, step_ff};
      step_inc = {1'b0, step_ff} + (SW+1)'(1);
      step_nx  = (step_inc >= PLEN) ? '0 : step_inc[SW-1:0];
      if (step_ext[SW+2:3] == '0) begin
         entry = cfg.pattern_words[step_ext[2:0]*LED_W +: LED_W];
      end else begin
         entry = '0;
      end
      rate_ok = (cfg.rate_select < RATE_LIM);
      rate_cl = rate_ok ? cfg.rate_select : RATE_LAST;
   end

   // next state
   always_comb begin
      leds_in  = leds_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      hold_in  = hold_ff;
      do_on    = 1'b0;
      do_off   = 1'b0;
      if (action) begin
         leds_in = led_value;
      end else begin
         case (phase_ff)
            PH_ON, PH_OFF: begin
               if (hold_ff > HOLD_W'(1)) begin
                  hold_in = hold_ff - HOLD_W'(1);
               end else if (phase_ff == PH_ON) begin
                  do_off = 1'b1;
               end else begin
                  do_on = 1'b1;
               end
            end
            default: do_on = 1'b1;
         endcase
      end

      // start of an on step; waits in start phase while the rate is invalid
      if (do_on) begin
         if (rate_ok) begin
            hold_in  = on_time(cfg.rate_select);
            phase_in = PH_ON;
         end else begin
            hold_in  = '0;
            phase_in = PH_START;
         end
      end
      if (do_off) begin
         hold_in  = off_time(rate_cl);
         phase_in = PH_OFF;
      end

      apply_en = ((do_on && rate_ok) || do_off) && !cfg.override_hold;
      if (apply_en) begin
         leds_in = entry;
         step_in = step_nx;
      end
   end

   // result of this item
   always_comb begin
      result.led_state   = leds_in;
      result.step_index  = STEP_OUT_W'({3'b000, step_in});
      result.in_on_phase = (phase_in == PH_ON);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leds_ff  <= '0;
         step_ff  <= '0;
         phase_ff <= PH_START;
         hold_ff  <= '0;
      end else if (item_en) begin
         leds_ff  <= leds_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

// File: rtl/led_blink_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer - top level
// Input register, step engine and result register around the CSR block.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per handshake: action 0 is a one millisecond
//   tick, action 1 sets the LEDs to led_value. Every item gives exactly one
//   result on rsp_ch: the LED mask, the pattern entry to apply next and
//   whether an on time is being held.
//   Configuration is written through csr_wr_en / csr_index / csr_wr_data
//   (0 pattern words, 1 rate select, 2 override hold) while no item is in
//   flight; writes take effect at the next edge.
//   From acceptance to rsp valid the item lands in the input register, then
//   passes through the step engine into the result register once that
//   register is free (empty, or its result taken).
//   Throughput is one item per cycle while rsp is taken; the step engine state
//   and both registers advance together, so a tick and a set pass alike.
//   When the receiver stalls the result register holds, the input register
//   fills and req ready then drops until rsp is taken.
//   Reset (synchronous) empties both registers, turns all LEDs off, sets
//   the step to entry 0 and the phase to start, and loads the register
//   defaults (pattern 0x01010101, rate 14, override off).
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer
   import lbps_pkg::*;
#(
   parameter int PATTERN_LEN  = LBPS_PATTERN_LEN,
   parameter int RATE_ENTRIES = LBPS_RATE_ENTRIES
)(
   input  logic                  clock,
   input  logic                  reset,
   lbps_req_if.sink              req_ch,
   lbps_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type          cfg;
   result_type       result;
   result_type       result_ff;
   logic             in_valid_ff, in_valid_in;
   logic             in_action_ff;
   logic [LED_W-1:0] in_led_ff;
   logic             out_valid_ff, out_valid_in;
   logic             advance;
   logic             req_take;

   lbps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   lbps_seq #(
      .PATTERN_LEN  (PATTERN_LEN),
      .RATE_ENTRIES (RATE_ENTRIES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item_en   (advance),
      .action    (in_action_ff),
      .led_value (in_led_ff),
      .result    (result)
   );

   // pipeline flow control
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
      req_take     = req_ch.valid && (!in_valid_ff || advance);
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   end

   assign req_ch.ready = !in_valid_ff || advance;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input item register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_ch.action;
         in_led_ff    <= req_ch.led_value;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.led_state   = result_ff.led_state;
   assign rsp_ch.step_index  = result_ff.step_index;
   assign rsp_ch.in_on_phase = result_ff.in_on_phase;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer - testbench
// Drives tick and set items through the request channel and keeps a cycle-free
// model of the LED sequencer alongside. Every result is checked field by field
// against the model in order. Register settings change between phases, and the
// handshakes are exercised with idle gaps, stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb;
   import lbps_pkg::*;

   // item actions
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_SET  = 1'b1;

   // on and off times in ms per rate code
   localparam int unsigned ON_MS [LBPS_RATE_ENTRIES] = '{
      40, 44, 50, 57, 67, 80, 100, 133, 160, 200, 240, 267, 400, 500, 750
   };
   localparam int unsigned OFF_MS [LBPS_RATE_ENTRIES] = '{
      10, 11, 13, 14, 16, 20, 25, 34, 40, 50, 58, 66, 100, 130, 750
   };

   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned HOLD_OFF_CYCLES = 60;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // LED sequencer model plus the queue of results still owed by the block
   class blink_tracker;
      logic [CSR_DATA_W-1:0] pattern_words;
      logic [RATE_W-1:0]     rate_code;
      logic                  hold_pattern;
      logic [LED_W-1:0]      leds;
      int unsigned           next_entry;
      phase_type             phase;
      int unsigned           hold_left;
      result_type            due[$];
      int unsigned           mismatches;

      function new();
         pattern_words = PATTERN_RESET;
         rate_code     = RATE_RESET;
         hold_pattern  = 1'b0;
         leds          = '0;
         next_entry    = 0;
         phase         = PH_START;
         hold_left     = 0;
         mismatches    = 0;
      endfunction

      function void set_config(logic [CSR_DATA_W-1:0] pat, logic [RATE_W-1:0] rate,
                               logic hold);
         pattern_words = pat;
         rate_code     = rate;
         hold_pattern  = hold;
      endfunction

      // one pattern step; override leaves the LEDs and the index alone
      function void take_step();
         if (hold_pattern)
            return;
         leds = (next_entry < PATTERN_SLOTS) ?
                pattern_words[LED_W*next_entry +: LED_W] : '0;
         next_entry = (next_entry + 1 >= LBPS_PATTERN_LEN) ? 0 : next_entry + 1;
      endfunction

      // on step, or back to start while the rate code is out of range
      function void start_on();
         if (rate_code < LBPS_RATE_ENTRIES) begin
            take_step();
            hold_left = ON_MS[rate_code];
            phase     = PH_ON;
         end else begin
            hold_left = 0;
            phase     = PH_START;
         end
      endfunction

      function void tick();
         int unsigned r;
         if (phase != PH_ON && phase != PH_OFF) begin
            start_on();
         end else if (hold_left > 1) begin
            hold_left--;
         end else if (phase == PH_ON) begin
            // off time clamps a bad rate code to the last entry
            r = (rate_code >= LBPS_RATE_ENTRIES) ? LBPS_RATE_ENTRIES - 1 : rate_code;
            take_step();
            hold_left = OFF_MS[r];
            phase     = PH_OFF;
         end else begin
            start_on();
         end
      endfunction

      function void note_item(logic act, logic [LED_W-1:0] val);
         result_type want;
         if (act == ACT_SET)
            leds = val;
         else
            tick();
         want.led_state   = leds;
         want.step_index  = STEP_OUT_W'(next_entry);
         want.in_on_phase = (phase == PH_ON);
         due.push_back(want);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (due.size() == 0) begin
            $error("unexpected result: led_state %0h step_index %0d in_on_phase %0b",
                   got.led_state, got.step_index, got.in_on_phase);
            mismatches++;
            return;
         end
         want = due.pop_front();
         if (got.led_state !== want.led_state) begin
            $error("led_state: expected %0h, got %0h", want.led_state, got.led_state);
            mismatches++;
         end
         if (got.step_index !== want.step_index) begin
            $error("step_index: expected %0d, got %0d", want.step_index, got.step_index);
            mismatches++;
         end
         if (got.in_on_phase !== want.in_on_phase) begin
            $error("in_on_phase: expected %0b, got %0b", want.in_on_phase,
                   got.in_on_phase);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   lbps_req_if req_ch ();
   lbps_rsp_if rsp_ch ();

   blink_tracker tracker = new();

   int unsigned send_gap_pct;
   int unsigned stall_pct;
   logic        hold_off_req;
   logic        hold_off_seen;
   int unsigned hold_off_left;
   int unsigned quiet_cycles;

   led_blink_pattern_sequencer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: check, then pick ready for the next edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_result({rsp_ch.led_state, rsp_ch.step_index,
                                  rsp_ch.in_on_phase});
         if (hold_off_req && !hold_off_seen) begin
            hold_off_seen <= 1'b1;
            hold_off_left <= HOLD_OFF_CYCLES;
            rsp_ch.ready  <= 1'b0;
         end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            rsp_ch.ready  <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog: too long without any item moving ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("** led_blink_pattern_sequencer: FAILED **");
         $finish;
      end
   end

   task automatic apply_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
         IDLE_SENDER: begin
            send_gap_pct = 86;
            stall_pct    = 0;
         end
         IDLE_RECEIVER: begin
            send_gap_pct = 0;
            stall_pct    = 86;
         end
         default: begin
            send_gap_pct = 18;
            stall_pct    = 18;
         end
      endcase
   endtask

   task automatic send_item(input logic act, input logic [LED_W-1:0] val);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.led_value <= val;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_item(act, val);
   endtask

   // drain, then write all three registers back to back
   task automatic configure(input logic [CSR_DATA_W-1:0] pat,
                            input logic [RATE_W-1:0] rate, input logic hold);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.due.size() != 0);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PATTERN_WORDS;
      csr_wr_data <= pat;
      @(posedge clock);
      csr_index   <= CSR_RATE_SELECT;
      csr_wr_data <= CSR_DATA_W'(rate);
      @(posedge clock);
      csr_index   <= CSR_OVERRIDE_HOLD;
      csr_wr_data <= CSR_DATA_W'(hold);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_config(pat, rate, hold);
   endtask

   // mostly ticks; optionally keep ticking until the model reaches a phase
   task automatic run_phase(input int unsigned count, input idle_mode_type mode,
                            input bit stop_on_phase, input phase_type stop_phase);
      int unsigned k;
      apply_idle(mode);
      for (k = 0; k < count; k++)
         send_item(($urandom_range(99) < 88) ? ACT_TICK : ACT_SET,
                   LED_W'($urandom_range(15)));
      while (stop_on_phase && tracker.phase != stop_phase)
         send_item(ACT_TICK, LED_W'($urandom_range(15)));
   endtask

   initial begin
      int unsigned ph;
      logic [CSR_DATA_W-1:0] mixed_pattern;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_PATTERN_WORDS;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_TICK;
      req_ch.led_value = '0;
      rsp_ch.ready     = 1'b0;
      hold_off_req     = 1'b0;
      hold_off_seen    = 1'b0;
      hold_off_left    = 0;
      quiet_cycles     = 0;
      send_gap_pct     = 0;
      stall_pct        = 0;
      mixed_pattern    = 32'h7F3C_9E61;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // direct sets at the mask extremes and two alternating masks, under reset settings
      send_item(ACT_SET, 4'h0);
      send_item(ACT_SET, 4'hF);
      send_item(ACT_SET, 4'hA);
      send_item(ACT_SET, 4'h5);

      // out-of-range rate: on step keeps retrying from start
      configure(mixed_pattern, 4'd15, 1'b0);
      repeat (3) send_item(ACT_TICK, 4'hF);

      // first on step under override leaves LEDs and index alone
      configure(mixed_pattern, 4'd0, 1'b1);
      send_item(ACT_TICK, 4'h0);
      send_item(ACT_TICK, 4'hA);
      send_item(ACT_SET, 4'h3);
      send_item(ACT_TICK, 4'h5);

      // fast rates, rotating idle modes and settings
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: configure(32'hFFFF_FFFF, 4'd0, 1'b0);
            1: configure($urandom(), 4'd1, 1'b1);
            2: configure(32'h0000_0000, RATE_W'($urandom_range(3)), 1'b0);
            default: configure($urandom(), RATE_W'($urandom_range(5)),
                               ($urandom_range(3) == 0));
         endcase
         // long receiver hold-off while items keep coming
         if (ph == 2)
            hold_off_req <= 1'b1;
         run_phase(40, idle_mode_type'(ph % 4), 1'b0, PH_START);
      end

      // out-of-range rate at the off step: off time falls back to the last entry
      run_phase(0, IDLE_BOTH, 1'b1, PH_ON);
      configure($urandom(), 4'd15, 1'b0);
      run_phase(0, IDLE_SENDER, 1'b1, PH_OFF);
      configure(32'hFFFF_FFFF, 4'd14, 1'b1);
      run_phase(250, IDLE_NONE, 1'b0, PH_START);
      configure(32'h0000_0000, 4'd15, 1'b0);
      run_phase(250, IDLE_RECEIVER, 1'b0, PH_START);
      configure($urandom(), 4'd1, 1'b0);
      run_phase(60, IDLE_BOTH, 1'b1, PH_ON);
      run_phase(100, IDLE_SENDER, 1'b0, PH_START);

      // let the pipeline drain before the verdict
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.due.size() != 0);
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("** led_blink_pattern_sequencer: PASSED **");
      else
         $display("** led_blink_pattern_sequencer: FAILED **");
      $finish;
   end

endmodule
